// ----- sv/wpcm_pkg.sv -----
package wpcm_pkg;

	// chunk ids, read most significant byte first
	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_FMT  = 32'h666d_7420;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;

	localparam int unsigned POS_W = 6;

	// header byte positions where a field completes, and the bounds of the id fields
	localparam logic [POS_W-1:0] POS_RIFF_ID   = 6'd3;
	localparam logic [POS_W-1:0] POS_WAVE_ID   = 6'd11;
	localparam logic [POS_W-1:0] POS_FMT_ID    = 6'd15;
	localparam logic [POS_W-1:0] POS_FORMAT    = 6'd21;
	localparam logic [POS_W-1:0] POS_CHANNELS  = 6'd23;
	localparam logic [POS_W-1:0] POS_RATE      = 6'd27;
	localparam logic [POS_W-1:0] POS_BITS      = 6'd35;
	localparam logic [POS_W-1:0] POS_DATA_ID   = 6'd39;
	localparam logic [POS_W-1:0] POS_DATA_SIZE = 6'd43;
	localparam logic [POS_W-1:0] POS_LAST_ID   = 6'd15;
	localparam logic [POS_W-1:0] POS_DID_FIRST = 6'd36;

	localparam logic [15:0] FMT_PCM = 16'd1;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_RIFF     = 4'd1;
	localparam logic [3:0] ERR_WAVE     = 4'd2;
	localparam logic [3:0] ERR_FMT_ID   = 4'd3;
	localparam logic [3:0] ERR_NOT_PCM  = 4'd4;
	localparam logic [3:0] ERR_CHANNELS = 4'd5;
	localparam logic [3:0] ERR_RATE     = 4'd6;
	localparam logic [3:0] ERR_BITS     = 4'd7;
	localparam logic [3:0] ERR_DATA_ID  = 4'd8;
	localparam logic [3:0] ERR_TRUNC    = 4'd9;

	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_DATA   = 2'd1,
		MODE_IGNORE = 2'd2
	} mode_t;

endpackage

// ----- sv/wav_pcm_header_parser.sv -----
// RIFF/WAVE PCM header parser.
// Input channel (in_valid/in_ready): one file byte per transfer, with
// end_of_file set on the file's last byte. Output channel (out_valid/
// out_ready): at most one result per input byte: a header result (kind 1)
// with channels, rate, bits and data length, one result per passed data
// byte (kind 0), or an error (kind 2) carrying the first failing check of
// the structure that just ended, or truncation. final_result marks the last
// result of a file.
// Each accepted byte is handled by the parse state registers; its
// result lands in the output register and is visible the next cycle.
// One byte is taken every cycle, limited only by the output
// register: a new byte is accepted whenever that register is empty or is
// being drained in the same cycle.
// Reset clears all parse state and empties the output register. A byte
// with end_of_file set returns the parser to its reset state once taken.
// When the receiver stalls, the result is held and in_ready drops until
// the held result is taken.
module wav_pcm_header_parser
	import wpcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  sample_byte,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [15:0] sample_bits,
	output logic [31:0] payload_length,
	output logic [3:0]  error_code,
	output logic        final_result
);

	// parse state
	logic [POS_W-1:0] pos_q, pos_d;
	mode_t            mode_q, mode_d;
	logic [3:0]       perr_q, perr_d;
	logic [31:0]      acc_q, acc_d;
	logic [15:0]      chan_q, chan_d;
	logic [31:0]      rate_q, rate_d;
	logic [15:0]      bits_q, bits_d;
	logic [31:0]      rem_q, rem_d;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  sample_q;
	logic [15:0] chan_out_q;
	logic [31:0] rate_out_q;
	logic [15:0] bits_out_q;
	logic [31:0] len_out_q;
	logic [3:0]  err_out_q;
	logic        fin_q;

	// result of the byte being taken
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_sample;
	logic [15:0] res_chan;
	logic [31:0] res_rate;
	logic [15:0] res_bits;
	logic [31:0] res_len;
	logic [3:0]  res_err;
	logic        res_fin;

	logic        accept;
	logic [31:0] be_word;
	logic [31:0] le_word;
	logic        id_field;
	logic [3:0]  check_err;
	logic        struct_end;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// big-endian shift for ids, little-endian shift for numbers
	assign be_word  = {acc_q[23:0], data_byte};
	assign le_word  = {data_byte, acc_q[31:8]};
	assign id_field = (pos_q <= POS_LAST_ID) ||
		(pos_q >= POS_DID_FIRST && pos_q <= POS_DATA_ID);
	assign struct_end = (pos_q == POS_WAVE_ID) || (pos_q == POS_BITS) ||
		(pos_q == POS_DATA_SIZE);

	always_comb begin
		pos_d      = pos_q;
		mode_d     = mode_q;
		perr_d     = perr_q;
		acc_d      = acc_q;
		chan_d     = chan_q;
		rate_d     = rate_q;
		bits_d     = bits_q;
		rem_d      = rem_q;
		check_err  = ERR_NONE;
		res_valid  = 1'b0;
		res_kind   = KIND_SAMPLE;
		res_sample = '0;
		res_chan   = '0;
		res_rate   = '0;
		res_bits   = '0;
		res_len    = '0;
		res_err    = ERR_NONE;
		res_fin    = 1'b0;

		case (mode_q)
			MODE_HEADER: begin
				acc_d = id_field ? be_word : le_word;
				case (pos_q)
					POS_RIFF_ID: begin
						if (be_word != ID_RIFF) check_err = ERR_RIFF;
					end
					POS_WAVE_ID: begin
						if (be_word != ID_WAVE) check_err = ERR_WAVE;
					end
					POS_FMT_ID: begin
						if (be_word != ID_FMT) check_err = ERR_FMT_ID;
					end
					POS_FORMAT: begin
						if (le_word[31:16] != FMT_PCM) check_err = ERR_NOT_PCM;
					end
					POS_CHANNELS: begin
						chan_d = le_word[31:16];
						if (le_word[31:16] == '0) check_err = ERR_CHANNELS;
					end
					POS_RATE: begin
						rate_d = le_word;
						if (le_word == '0) check_err = ERR_RATE;
					end
					POS_BITS: begin
						bits_d = le_word[31:16];
						if (le_word[31:16] == '0 || le_word[18:16] != 3'd0)
							check_err = ERR_BITS;
					end
					POS_DATA_ID: begin
						if (be_word != ID_DATA) check_err = ERR_DATA_ID;
					end
					POS_DATA_SIZE: begin
						rem_d = le_word;
					end
					default: begin
					end
				endcase

				// keep only the first failing check
				if (perr_q == ERR_NONE) perr_d = check_err;

				if (struct_end && perr_d != ERR_NONE) begin
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_err   = perr_d;
					res_fin   = 1'b1;
					mode_d    = MODE_IGNORE;
				end else if (pos_q == POS_DATA_SIZE) begin
					res_valid = 1'b1;
					if (end_of_file && le_word != '0) begin
						res_kind = KIND_ERROR;
						res_err  = ERR_TRUNC;
						res_fin  = 1'b1;
					end else begin
						res_kind = KIND_HEADER;
						res_chan = chan_q;
						res_rate = rate_q;
						res_bits = bits_q;
						res_len  = le_word;
						res_fin  = (le_word == '0);
						mode_d   = (le_word != '0) ? MODE_DATA : MODE_IGNORE;
					end
				end else if (end_of_file) begin
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_err   = ERR_TRUNC;
					res_fin   = 1'b1;
				end else begin
					pos_d = pos_q + POS_W'(1);
				end
			end
			MODE_DATA: begin
				if (rem_q != '0) begin
					res_valid = 1'b1;
					if (end_of_file && rem_q[31:1] != '0) begin
						res_kind = KIND_ERROR;
						res_err  = ERR_TRUNC;
						res_fin  = 1'b1;
					end else begin
						rem_d      = rem_q - 32'd1;
						res_kind   = KIND_SAMPLE;
						res_sample = data_byte;
						res_fin    = (rem_q == 32'd1);
						if (rem_q == 32'd1) mode_d = MODE_IGNORE;
					end
				end
			end
			default: begin
				// ignore until end of file
			end
		endcase

		// end of file rearms the parser
		if (end_of_file) begin
			pos_d  = '0;
			mode_d = MODE_HEADER;
			perr_d = ERR_NONE;
			acc_d  = '0;
			chan_d = '0;
			rate_d = '0;
			bits_d = '0;
			rem_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mode_q <= MODE_HEADER;
			perr_q <= ERR_NONE;
			acc_q  <= '0;
			chan_q <= '0;
			rate_q <= '0;
			bits_q <= '0;
			rem_q  <= '0;
		end else if (accept) begin
			pos_q  <= pos_d;
			mode_q <= mode_d;
			perr_q <= perr_d;
			acc_q  <= acc_d;
			chan_q <= chan_d;
			rate_q <= rate_d;
			bits_q <= bits_d;
			rem_q  <= rem_d;
		end
	end

	// output register: load on a transfer that makes a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			kind_q     <= res_kind;
			sample_q   <= res_sample;
			chan_out_q <= res_chan;
			rate_out_q <= res_rate;
			bits_out_q <= res_bits;
			len_out_q  <= res_len;
			err_out_q  <= res_err;
			fin_q      <= res_fin;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign sample_byte    = sample_q;
	assign channel_count  = chan_out_q;
	assign rate_hz        = rate_out_q;
	assign sample_bits    = bits_out_q;
	assign payload_length = len_out_q;
	assign error_code     = err_out_q;
	assign final_result   = fin_q;

endmodule
